// ===== hdl/rgbdg_pkg.sv =====
// shared constants, types and helpers for the dithered gradient pixel pipeline
package rgbdg_pkg;

   localparam int unsigned SCREEN_SIDE = 240;
   localparam int unsigned SIDE_W      = $clog2(SCREEN_SIDE);

   localparam int unsigned COLOUR_W    = 16;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned COORD_W     = 8;
   localparam int unsigned T_W         = 9;
   localparam int unsigned MAG_W       = 6;
   localparam int unsigned QUO_W       = 6;
   localparam int unsigned REM_W       = T_W + QUO_W;
   localparam int unsigned POS_W       = 12;
   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned CHANNELS    = 3;
   localparam int unsigned STEPS_PER_STAGE = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_START_COLOUR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_END_COLOUR   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DIRECTION    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RECT_WIDTH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RECT_HEIGHT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y     = 3'd6;

   localparam logic [2:0] DIR_UP         = 3'd0;
   localparam logic [2:0] DIR_DOWN       = 3'd1;
   localparam logic [2:0] DIR_LEFT       = 3'd2;
   localparam logic [2:0] DIR_RIGHT      = 3'd3;
   localparam logic [2:0] DIR_UP_LEFT    = 3'd4;
   localparam logic [2:0] DIR_UP_RIGHT   = 3'd5;
   localparam logic [2:0] DIR_DOWN_LEFT  = 3'd6;
   localparam logic [2:0] DIR_DOWN_RIGHT = 3'd7;

   localparam logic [3:0] BAYER4 [0:15] = '{
      4'd0,  4'd8,  4'd2,  4'd10,
      4'd12, 4'd4,  4'd14, 4'd6,
      4'd3,  4'd11, 4'd1,  4'd9,
      4'd15, 4'd7,  4'd13, 4'd5
   };
   localparam logic [3:0] DITHER_LEVEL = 4'd8;

   typedef struct packed {
      logic [COLOUR_W-1:0] start_colour;
      logic [COLOUR_W-1:0] end_colour;
      logic [2:0]          direction;
      logic [COORD_W-1:0]  rect_width;
      logic [COORD_W-1:0]  rect_height;
      logic signed [8:0]   origin_x;
      logic signed [8:0]   origin_y;
   } cfg_type;

   typedef struct packed {
      logic                             in_rect;
      logic                             dither;
      logic                             write_enable;
      logic [ADDR_W-1:0]                address;
      logic [CHANNELS-1:0]              neg;
      logic [CHANNELS-1:0][REM_W-1:0]   rem;
      logic [CHANNELS-1:0][QUO_W-1:0]   quo;
      logic [REM_W-1:0]                 dshift;
   } div_word_type;

   // channel 0 red, 1 green, 2 blue, widened to six bits
   function automatic logic [MAG_W-1:0] channel_of(input logic [COLOUR_W-1:0] colour,
                                                   input int unsigned idx);
      logic [MAG_W-1:0] value;
      case (idx)
         0: value = {1'b0, colour[15:11]};
         1: value = colour[10:5];
         default: value = {1'b0, colour[4:0]};
      endcase
      return value;
   endfunction

   function automatic logic dither_hit(input logic [1:0] row, input logic [1:0] col);
      return BAYER4[{row, col}] > DITHER_LEVEL;
   endfunction

endpackage

// ===== hdl/rgbdg_front.sv =====
// ramp position, bounds, screen address and channel products (two stages)
module rgbdg_front (
   input  logic                           clock,
   input  logic                           reset,
   input  rgbdg_pkg::cfg_type             cfg,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [rgbdg_pkg::COORD_W-1:0]  in_col,
   input  logic [rgbdg_pkg::COORD_W-1:0]  in_row,
   output logic                           out_valid,
   input  logic                           out_ready,
   output rgbdg_pkg::div_word_type        out_word
);

   logic                               a_ready;
   logic                               b_ready;
   logic                               a_valid_ff;
   logic                               a_inside_in,   a_inside_ff;
   logic                               a_dither_in,   a_dither_ff;
   logic                               a_onscreen_in, a_onscreen_ff;
   logic [rgbdg_pkg::T_W-1:0]          a_t_in,        a_t_ff;
   logic [rgbdg_pkg::SIDE_W-1:0]       a_px_in,       a_px_ff;
   logic [rgbdg_pkg::SIDE_W-1:0]       a_py_in,       a_py_ff;
   logic [rgbdg_pkg::T_W-1:0]          left_col;
   logic [rgbdg_pkg::T_W-1:0]          left_row;
   logic signed [rgbdg_pkg::POS_W-1:0] px;
   logic signed [rgbdg_pkg::POS_W-1:0] py;

   logic                               b_valid_ff;
   rgbdg_pkg::div_word_type            b_word_in, b_word_ff;
   logic [rgbdg_pkg::T_W-1:0]          span;
   logic [31:0]                        addr_full;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // stage a: ramp position and bounds
   always_comb begin
      a_inside_in = (in_col < cfg.rect_width) && (in_row < cfg.rect_height);
      left_col    = rgbdg_pkg::T_W'(cfg.rect_width) - rgbdg_pkg::T_W'(in_col);
      left_row    = rgbdg_pkg::T_W'(cfg.rect_height) - rgbdg_pkg::T_W'(in_row);
      case (cfg.direction)
         rgbdg_pkg::DIR_UP:        a_t_in = left_row;
         rgbdg_pkg::DIR_DOWN:      a_t_in = rgbdg_pkg::T_W'(in_row);
         rgbdg_pkg::DIR_LEFT:      a_t_in = left_col;
         rgbdg_pkg::DIR_RIGHT:     a_t_in = rgbdg_pkg::T_W'(in_col);
         rgbdg_pkg::DIR_UP_LEFT:   a_t_in = left_col + left_row;
         rgbdg_pkg::DIR_UP_RIGHT:  a_t_in = rgbdg_pkg::T_W'(in_col) + left_row;
         rgbdg_pkg::DIR_DOWN_LEFT: a_t_in = left_col + rgbdg_pkg::T_W'(in_row);
         default:                  a_t_in = rgbdg_pkg::T_W'(in_col) + rgbdg_pkg::T_W'(in_row);
      endcase
      a_dither_in = rgbdg_pkg::dither_hit(in_row[1:0], in_col[1:0]);
      px = rgbdg_pkg::POS_W'(cfg.origin_x) + signed'(rgbdg_pkg::POS_W'(in_col));
      py = rgbdg_pkg::POS_W'(cfg.origin_y) + signed'(rgbdg_pkg::POS_W'(in_row));
      a_onscreen_in = !px[rgbdg_pkg::POS_W-1]
                    && ($unsigned(px) < rgbdg_pkg::POS_W'(rgbdg_pkg::SCREEN_SIDE))
                    && !py[rgbdg_pkg::POS_W-1]
                    && ($unsigned(py) < rgbdg_pkg::POS_W'(rgbdg_pkg::SCREEN_SIDE));
      a_px_in = px[rgbdg_pkg::SIDE_W-1:0];
      a_py_in = py[rgbdg_pkg::SIDE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_inside_ff   <= a_inside_in;
         a_dither_ff   <= a_dither_in;
         a_onscreen_ff <= a_onscreen_in;
         a_t_ff        <= a_t_in;
         a_px_ff       <= a_px_in;
         a_py_ff       <= a_py_in;
      end
   end

   // stage b: address and per-channel dividend
   always_comb begin
      logic [rgbdg_pkg::MAG_W-1:0] s_ch;
      logic [rgbdg_pkg::MAG_W-1:0] e_ch;
      logic [rgbdg_pkg::MAG_W-1:0] mag;
      span      = rgbdg_pkg::T_W'(cfg.rect_width) + rgbdg_pkg::T_W'(cfg.rect_height);
      addr_full = 32'(a_py_ff) * 32'(rgbdg_pkg::SCREEN_SIDE) + 32'(a_px_ff);
      b_word_in = '0;
      b_word_in.in_rect      = a_inside_ff;
      b_word_in.dither       = a_dither_ff;
      b_word_in.write_enable = a_inside_ff && a_onscreen_ff;
      b_word_in.address      = (a_inside_ff && a_onscreen_ff) ?
                               addr_full[rgbdg_pkg::ADDR_W-1:0] : '0;
      b_word_in.dshift       = {span, {rgbdg_pkg::QUO_W{1'b0}}};
      for (int ch = 0; ch < rgbdg_pkg::CHANNELS; ch++) begin
         s_ch = rgbdg_pkg::channel_of(cfg.start_colour, ch);
         e_ch = rgbdg_pkg::channel_of(cfg.end_colour, ch);
         b_word_in.neg[ch] = e_ch < s_ch;
         mag = (e_ch < s_ch) ? (s_ch - e_ch) : (e_ch - s_ch);
         b_word_in.rem[ch] = rgbdg_pkg::REM_W'(mag) * rgbdg_pkg::REM_W'(a_t_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_word_ff <= b_word_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_word  = b_word_ff;

endmodule

// ===== hdl/rgbdg_div_step.sv =====
// one pipeline stage of the restoring divider, two quotient bits per channel
module rgbdg_div_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rgbdg_pkg::div_word_type  in_word,
   output logic                     out_valid,
   input  logic                     out_ready,
   output rgbdg_pkg::div_word_type  out_word
);

   logic                    valid_ff;
   rgbdg_pkg::div_word_type word_in, word_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      word_in = in_word;
      for (int s = 0; s < rgbdg_pkg::STEPS_PER_STAGE; s++) begin
         word_in.dshift = word_in.dshift >> 1;
         for (int ch = 0; ch < rgbdg_pkg::CHANNELS; ch++) begin
            if (word_in.rem[ch] >= word_in.dshift) begin
               word_in.rem[ch] = word_in.rem[ch] - word_in.dshift;
               word_in.quo[ch] = {word_in.quo[ch][rgbdg_pkg::QUO_W-2:0], 1'b1};
            end else begin
               word_in.quo[ch] = {word_in.quo[ch][rgbdg_pkg::QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // partial remainder stays below the current shifted divisor
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && word_ff.in_rect |->
         (word_ff.rem[0] < word_ff.dshift) && (word_ff.rem[1] < word_ff.dshift)
         && (word_ff.rem[2] < word_ff.dshift))
      else $error("divider remainder out of range");

endmodule

// ===== hdl/rgbdg_back.sv =====
// signed quotient to channels, packing, dither and the output register
module rgbdg_back (
   input  logic                            clock,
   input  logic                            reset,
   input  rgbdg_pkg::cfg_type              cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  rgbdg_pkg::div_word_type         in_word,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [rgbdg_pkg::COLOUR_W-1:0]  out_colour,
   output logic [rgbdg_pkg::ADDR_W-1:0]    out_address,
   output logic                            out_write_enable
);

   logic                              valid_ff;
   logic [rgbdg_pkg::COLOUR_W-1:0]    colour_in, colour_ff;
   logic [rgbdg_pkg::ADDR_W-1:0]      address_in, address_ff;
   logic                              we_in, we_ff;
   logic [rgbdg_pkg::CHANNELS-1:0][rgbdg_pkg::MAG_W:0] chan;
   logic [rgbdg_pkg::COLOUR_W-1:0]    packed_colour;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      logic [rgbdg_pkg::MAG_W:0] q;
      logic [rgbdg_pkg::MAG_W:0] delta;
      for (int ch = 0; ch < rgbdg_pkg::CHANNELS; ch++) begin
         q        = {1'b0, in_word.quo[ch]};
         delta    = in_word.neg[ch] ? ((rgbdg_pkg::MAG_W + 1)'(0) - q) : q;
         chan[ch] = {1'b0, rgbdg_pkg::channel_of(cfg.start_colour, ch)} + delta;
      end
      packed_colour = {chan[0][4:0], chan[1][5:0], chan[2][4:0]};
      if (in_word.dither && (packed_colour != cfg.end_colour)) begin
         packed_colour = packed_colour + rgbdg_pkg::COLOUR_W'(1);
      end
      if (in_word.in_rect) begin
         colour_in = packed_colour;
      end else begin
         colour_in = '0;
      end
      address_in = in_word.address;
      we_in      = in_word.write_enable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         colour_ff  <= colour_in;
         address_ff <= address_in;
         we_ff      <= we_in;
      end
   end

   assign out_valid        = valid_ff;
   assign out_colour       = colour_ff;
   assign out_address      = address_ff;
   assign out_write_enable = we_ff;

endmodule

// ===== hdl/rgb565_dithered_gradient_pixel.sv =====
// gradient pixel generator: six-stage pipeline, one word per cycle while rsp is not stalled
// an accepted req word passes stage a, stage b, three divider stages and the back register, which drives rsp_valid
// throughput: one word per clock unless rsp stalls; three divider stages resolve two quotient bits each
// a stalled rsp holds the pipeline back stage by stage, bubbles are squeezed out
// reset clears all valid bits and returns the configuration registers to their reset values
module rgb565_dithered_gradient_pixel (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [rgbdg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rgbdg_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rgbdg_pkg::COORD_W-1:0]      req_local_col,
   input  logic [rgbdg_pkg::COORD_W-1:0]      req_local_row,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rgbdg_pkg::COLOUR_W-1:0]     rsp_pixel_colour,
   output logic [rgbdg_pkg::ADDR_W-1:0]       rsp_pixel_address,
   output logic                               rsp_write_enable
);

   rgbdg_pkg::cfg_type      cfg_in, cfg_ff;
   logic                    f_valid, f_ready;
   rgbdg_pkg::div_word_type f_word;
   logic                    d1_valid, d1_ready;
   rgbdg_pkg::div_word_type d1_word;
   logic                    d2_valid, d2_ready;
   rgbdg_pkg::div_word_type d2_word;
   logic                    d3_valid, d3_ready;
   rgbdg_pkg::div_word_type d3_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rgbdg_pkg::REG_START_COLOUR: cfg_in.start_colour = csr_data;
            rgbdg_pkg::REG_END_COLOUR:   cfg_in.end_colour   = csr_data;
            rgbdg_pkg::REG_DIRECTION:    cfg_in.direction    = csr_data[2:0];
            rgbdg_pkg::REG_RECT_WIDTH:   cfg_in.rect_width   = csr_data[7:0];
            rgbdg_pkg::REG_RECT_HEIGHT:  cfg_in.rect_height  = csr_data[7:0];
            rgbdg_pkg::REG_ORIGIN_X:     cfg_in.origin_x     = signed'(csr_data[8:0]);
            rgbdg_pkg::REG_ORIGIN_Y:     cfg_in.origin_y     = signed'(csr_data[8:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_colour <= '0;
         cfg_ff.end_colour   <= '0;
         cfg_ff.direction    <= rgbdg_pkg::DIR_UP;
         cfg_ff.rect_width   <= rgbdg_pkg::COORD_W'(1);
         cfg_ff.rect_height  <= rgbdg_pkg::COORD_W'(1);
         cfg_ff.origin_x     <= '0;
         cfg_ff.origin_y     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rgbdg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_col    (req_local_col),
      .in_row    (req_local_row),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_word  (f_word)
   );

   rgbdg_div_step u_div1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_word   (f_word),
      .out_valid (d1_valid),
      .out_ready (d1_ready),
      .out_word  (d1_word)
   );

   rgbdg_div_step u_div2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_valid),
      .in_ready  (d1_ready),
      .in_word   (d1_word),
      .out_valid (d2_valid),
      .out_ready (d2_ready),
      .out_word  (d2_word)
   );

   rgbdg_div_step u_div3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d2_valid),
      .in_ready  (d2_ready),
      .in_word   (d2_word),
      .out_valid (d3_valid),
      .out_ready (d3_ready),
      .out_word  (d3_word)
   );

   rgbdg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (d3_valid),
      .in_ready         (d3_ready),
      .in_word          (d3_word),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_colour       (rsp_pixel_colour),
      .out_address      (rsp_pixel_address),
      .out_write_enable (rsp_write_enable)
   );

   // back-pressure only starts at a held output word
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // unwritten pixels carry a zero address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_pixel_address == '0)
      else $error("address set on unwritten pixel");

   // divider has resolved the full quotient by its last stage
   assert property (@(posedge clock) disable iff (reset)
      d3_valid && d3_word.in_rect |->
         d3_word.dshift == (rgbdg_pkg::REM_W'(cfg_ff.rect_width)
                            + rgbdg_pkg::REM_W'(cfg_ff.rect_height)))
      else $error("divisor not aligned after last divider stage");

   // nothing leaves the pipeline straight after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("output valid after reset");

endmodule
